@@ rtl/core/bdlp_pkg.sv @@
`timescale 1ns / 1ps

package bdlp_pkg;

    typedef enum logic [1:0] {
        MODE_IDLE     = 2'd0,
        MODE_DEBOUNCE = 2'd1,
        MODE_PRESSED  = 2'd2,
        MODE_LONG     = 2'd3
    } t_mode;

    typedef enum logic [1:0] {
        EV_NONE  = 2'd0,
        EV_SHORT = 2'd1,
        EV_LONG  = 2'd2
    } t_event;

    // register index is paddr[2]
    localparam logic REG_LONG_PRESS = 1'b0;
    localparam logic REG_DEBOUNCE   = 1'b1;

    localparam int ADDR_W = 3;

    localparam logic [15:0] LONG_PRESS_RST = 16'd1000;
    localparam logic [7:0]  DEBOUNCE_RST   = 8'd5;
    localparam logic [7:0]  COUNT_MAX      = 8'd255;

    typedef struct packed {
        t_mode       mode;
        logic [7:0]  low_count;
        logic [31:0] press_start;
    } t_state;

endpackage

@@ rtl/core/bdlp_regs.sv @@
`timescale 1ns / 1ps

module bdlp_regs (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        psel,
    input  logic                        penable,
    input  logic                        pwrite,
    input  logic [bdlp_pkg::ADDR_W-1:0] paddr,
    input  logic [31:0]                 pwdata,
    output logic [31:0]                 prdata,
    output logic                        pready,
    output logic [15:0]                 o_long_press_ms,
    output logic [7:0]                  o_debounce_count
);

    logic [15:0] r_long_press_ms;
    logic [7:0]  r_debounce_count;
    logic        wr_en;

    assign pready = 1'b1;
    assign wr_en  = psel && penable && pwrite;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_long_press_ms  <= bdlp_pkg::LONG_PRESS_RST;
            r_debounce_count <= bdlp_pkg::DEBOUNCE_RST;
        end else if (wr_en) begin
            case (paddr[2])
                bdlp_pkg::REG_LONG_PRESS: r_long_press_ms  <= pwdata[15:0];
                bdlp_pkg::REG_DEBOUNCE:   r_debounce_count <= pwdata[7:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        case (paddr[2])
            bdlp_pkg::REG_LONG_PRESS: prdata = {16'd0, r_long_press_ms};
            bdlp_pkg::REG_DEBOUNCE:   prdata = {24'd0, r_debounce_count};
            default:                  prdata = 32'd0;
        endcase
    end

    assign o_long_press_ms  = r_long_press_ms;
    assign o_debounce_count = r_debounce_count;

endmodule

@@ rtl/core/bdlp_step.sv @@
`timescale 1ns / 1ps

module bdlp_step (
    input  bdlp_pkg::t_state  i_state,
    input  logic              i_level,
    input  logic              i_edge_seen,
    input  logic [31:0]       i_now_ms,
    input  logic [15:0]       i_long_press_ms,
    input  logic [7:0]        i_debounce_count,
    output bdlp_pkg::t_state  o_state,
    output bdlp_pkg::t_event  o_event,
    output logic [31:0]       o_duration
);

    logic [7:0]  cnt_base;
    logic [7:0]  cnt_inc;
    logic [31:0] held;
    logic        deb_path;

    // an edge in idle starts debounce with a fresh count on the same poll
    assign cnt_base = (i_state.mode == bdlp_pkg::MODE_IDLE) ? 8'd0 : i_state.low_count;
    assign cnt_inc  = (cnt_base == bdlp_pkg::COUNT_MAX) ? cnt_base : cnt_base + 8'd1;
    assign held     = i_now_ms - i_state.press_start;

    always_comb begin
        o_state  = i_state;
        o_event  = bdlp_pkg::EV_NONE;
        deb_path = 1'b0;

        case (i_state.mode)
            bdlp_pkg::MODE_IDLE:     deb_path = i_edge_seen;
            bdlp_pkg::MODE_DEBOUNCE: deb_path = 1'b1;
            bdlp_pkg::MODE_PRESSED: begin
                if (i_level) begin
                    o_event      = bdlp_pkg::EV_SHORT;
                    o_state.mode = bdlp_pkg::MODE_IDLE;
                end else if (held >= {16'd0, i_long_press_ms}) begin
                    o_event      = bdlp_pkg::EV_LONG;
                    o_state.mode = bdlp_pkg::MODE_LONG;
                end
            end
            bdlp_pkg::MODE_LONG: begin
                if (i_level) begin
                    o_state.mode = bdlp_pkg::MODE_IDLE;
                end
            end
            default: o_state.mode = bdlp_pkg::MODE_IDLE;
        endcase

        if (deb_path) begin
            if (i_level) begin
                o_state.mode      = bdlp_pkg::MODE_IDLE;
                o_state.low_count = cnt_base;
            end else begin
                o_state.low_count = cnt_inc;
                o_state.mode      = bdlp_pkg::MODE_DEBOUNCE;
                if (cnt_inc >= i_debounce_count) begin
                    o_state.press_start = i_now_ms;
                    // accepted press is checked at once with zero hold time
                    if (i_long_press_ms == 16'd0) begin
                        o_state.mode = bdlp_pkg::MODE_LONG;
                        o_event      = bdlp_pkg::EV_LONG;
                    end else begin
                        o_state.mode = bdlp_pkg::MODE_PRESSED;
                    end
                end
            end
        end

        if (o_state.mode == bdlp_pkg::MODE_PRESSED || o_state.mode == bdlp_pkg::MODE_LONG) begin
            o_duration = i_now_ms - o_state.press_start;
        end else begin
            o_duration = 32'd0;
        end
    end

endmodule

@@ rtl/core/button_debounce_long_press_fsm.sv @@
`timescale 1ns / 1ps
// Channel   Direction  Handshake          Word
// poll      in         i_valid / o_stall  i_level, i_edge_seen, i_now_ms
// result    out        o_valid / i_stall  o_event_res, o_fsm_state, o_press_duration
// config    in         APB (psel..pready) long_press_ms @0x0, debounce_count @0x4
//
// One word per cycle sustained while the result is not stalled; a poll lands in the
// input register at the accepting edge and passes to the result register unless stalled.
// The mode, count and press start registers close a loop through bdlp_step.
// Synchronous active-low reset returns to idle and reloads the register defaults.
// A stalled result holds; o_stall rises only when both stages are full.

module button_debounce_long_press_fsm (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_valid,
    output logic                        o_stall,
    input  logic                        i_level,
    input  logic                        i_edge_seen,
    input  logic [31:0]                 i_now_ms,
    output logic                        o_valid,
    input  logic                        i_stall,
    output logic [1:0]                  o_event_res,
    output logic [1:0]                  o_fsm_state,
    output logic [31:0]                 o_press_duration,
    input  logic                        psel,
    input  logic                        penable,
    input  logic                        pwrite,
    input  logic [bdlp_pkg::ADDR_W-1:0] paddr,
    input  logic [31:0]                 pwdata,
    output logic [31:0]                 prdata,
    output logic                        pready
);

    logic [15:0] long_press_ms;
    logic [7:0]  debounce_count;

    logic        r_in_vld;
    logic        r_level;
    logic        r_edge_seen;
    logic [31:0] r_now_ms;

    logic        r_out_vld;
    logic [1:0]  r_event_res;
    logic [1:0]  r_fsm_state;
    logic [31:0] r_press_duration;

    bdlp_pkg::t_state r_state;
    bdlp_pkg::t_state n_state;
    bdlp_pkg::t_event n_event;
    logic [31:0]      n_duration;

    logic advance;
    logic in_take;

    bdlp_regs u_regs (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .psel             (psel),
        .penable          (penable),
        .pwrite           (pwrite),
        .paddr            (paddr),
        .pwdata           (pwdata),
        .prdata           (prdata),
        .pready           (pready),
        .o_long_press_ms  (long_press_ms),
        .o_debounce_count (debounce_count)
    );

    bdlp_step u_step (
        .i_state          (r_state),
        .i_level          (r_level),
        .i_edge_seen      (r_edge_seen),
        .i_now_ms         (r_now_ms),
        .i_long_press_ms  (long_press_ms),
        .i_debounce_count (debounce_count),
        .o_state          (n_state),
        .o_event          (n_event),
        .o_duration       (n_duration)
    );

    assign advance = !r_out_vld || !i_stall;
    assign o_stall = r_in_vld && !advance;
    assign in_take = i_valid && !o_stall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_vld  <= 1'b0;
            r_out_vld <= 1'b0;
            r_state   <= '{mode: bdlp_pkg::MODE_IDLE, low_count: 8'd0, press_start: 32'd0};
        end else begin
            if (in_take) begin
                r_in_vld <= 1'b1;
            end else if (advance) begin
                r_in_vld <= 1'b0;
            end
            if (advance) begin
                r_out_vld <= r_in_vld;
            end
            // commit the state update only when the word moves to the result register
            if (advance && r_in_vld) begin
                r_state <= n_state;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_take) begin
            r_level     <= i_level;
            r_edge_seen <= i_edge_seen;
            r_now_ms    <= i_now_ms;
        end
        if (advance && r_in_vld) begin
            r_event_res      <= n_event;
            r_fsm_state      <= n_state.mode;
            r_press_duration <= n_duration;
        end
    end

    assign o_valid          = r_out_vld;
    assign o_event_res      = r_event_res;
    assign o_fsm_state      = r_fsm_state;
    assign o_press_duration = r_press_duration;

    a_dur_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && (o_fsm_state == bdlp_pkg::MODE_IDLE ||
                     o_fsm_state == bdlp_pkg::MODE_DEBOUNCE)) |-> o_press_duration == 32'd0)
        else $error("duration not zero outside a held press");

    a_short_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_event_res == bdlp_pkg::EV_SHORT) |-> o_fsm_state == bdlp_pkg::MODE_IDLE)
        else $error("short press reported without return to idle");

    a_long_held: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_event_res == bdlp_pkg::EV_LONG) |-> o_fsm_state == bdlp_pkg::MODE_LONG)
        else $error("long press reported outside long-held state");

    a_state_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(advance && r_in_vld) |=> $stable(r_state))
        else $error("state changed without a word completing");

endmodule

@@ verif/bdlp_report_checker.sv @@
`timescale 1ns / 1ps

module bdlp_report_checker (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_poll_valid,
    input  logic                        i_poll_stall,
    input  logic                        i_level,
    input  logic                        i_edge_seen,
    input  logic [31:0]                 i_now_ms,
    input  logic                        i_res_valid,
    input  logic                        i_res_stall,
    input  logic [1:0]                  i_event_res,
    input  logic [1:0]                  i_fsm_state,
    input  logic [31:0]                 i_press_duration,
    input  logic                        i_psel,
    input  logic                        i_penable,
    input  logic                        i_pwrite,
    input  logic                        i_pready,
    input  logic [bdlp_pkg::ADDR_W-1:0] i_paddr,
    input  logic [31:0]                 i_pwdata,
    output int                          o_fail_count,
    output int                          o_pending
);

    typedef struct packed {
        bdlp_pkg::t_event ev;
        bdlp_pkg::t_mode  st;
        logic [31:0]      dur;
    } t_report;

    t_report expected_reports[$];

    bdlp_pkg::t_mode mode_q;
    logic            edge_pend;
    logic            long_fired;
    logic [7:0]      low_cnt;
    logic [31:0]     press_t0;
    logic [15:0]     long_ms;
    logic [7:0]      deb_cnt;

    int fail_count = 0;
    int pending_n  = 0;

    assign o_fail_count = fail_count;
    assign o_pending    = pending_n;

    task automatic log_fail(input string what);
        fail_count++;
        if (fail_count <= 10) begin
            $display("%0t checker: %s", $time, what);
        end
    endtask

    // Advance the button state by one poll and queue the word it should produce.
    task automatic predict_poll(input logic lvl, input logic edg, input logic [31:0] now);
        t_report     r;
        logic [31:0] held;
        r.ev  = bdlp_pkg::EV_NONE;
        r.dur = '0;
        if (edg && mode_q == bdlp_pkg::MODE_IDLE) begin
            edge_pend = 1'b1;
            low_cnt   = '0;
        end
        if (mode_q == bdlp_pkg::MODE_IDLE && edge_pend) begin
            edge_pend = 1'b0;
            low_cnt   = '0;
            mode_q    = bdlp_pkg::MODE_DEBOUNCE;
        end
        if (mode_q == bdlp_pkg::MODE_DEBOUNCE) begin
            if (!lvl) begin
                if (low_cnt != 8'hFF) begin
                    low_cnt = low_cnt + 8'd1;
                end
                if (low_cnt >= deb_cnt) begin
                    mode_q     = bdlp_pkg::MODE_PRESSED;
                    press_t0   = now;
                    long_fired = 1'b0;
                end
            end else begin
                mode_q = bdlp_pkg::MODE_IDLE;
            end
        end
        if (mode_q == bdlp_pkg::MODE_PRESSED) begin
            held = now - press_t0;
            if (lvl) begin
                if (long_fired) begin
                    long_fired = 1'b0;
                end else begin
                    r.ev = bdlp_pkg::EV_SHORT;
                end
                mode_q = bdlp_pkg::MODE_IDLE;
            end else if (held >= {16'd0, long_ms} && !long_fired) begin
                long_fired = 1'b1;
                mode_q     = bdlp_pkg::MODE_LONG;
                r.ev       = bdlp_pkg::EV_LONG;
            end
        end
        if (mode_q == bdlp_pkg::MODE_LONG && lvl) begin
            mode_q = bdlp_pkg::MODE_IDLE;
        end
        if (mode_q == bdlp_pkg::MODE_PRESSED || mode_q == bdlp_pkg::MODE_LONG) begin
            r.dur = now - press_t0;
        end
        r.st = mode_q;
        expected_reports.push_back(r);
    endtask

    task automatic check_report();
        t_report exp_r;
        if (expected_reports.size() == 0) begin
            log_fail($sformatf("result word with nothing expected: ev=%0d st=%0d dur=%0d",
                               i_event_res, i_fsm_state, i_press_duration));
        end else begin
            exp_r = expected_reports.pop_front();
            if (i_event_res !== exp_r.ev || i_fsm_state !== exp_r.st ||
                i_press_duration !== exp_r.dur) begin
                log_fail($sformatf("mismatch: exp ev=%0d st=%0d dur=%0d, got ev=%0d st=%0d dur=%0d",
                                   exp_r.ev, exp_r.st, exp_r.dur,
                                   i_event_res, i_fsm_state, i_press_duration));
            end
        end
    endtask

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            mode_q     = bdlp_pkg::MODE_IDLE;
            edge_pend  = 1'b0;
            long_fired = 1'b0;
            low_cnt    = '0;
            press_t0   = '0;
            long_ms    = bdlp_pkg::LONG_PRESS_RST;
            deb_cnt    = bdlp_pkg::DEBOUNCE_RST;
            expected_reports.delete();
        end else begin
            if (i_res_valid && !i_res_stall) begin
                check_report();
            end
            if (i_poll_valid && !i_poll_stall) begin
                predict_poll(i_level, i_edge_seen, i_now_ms);
            end
            if (i_psel && i_penable && i_pwrite && i_pready) begin
                if (i_paddr[2] == bdlp_pkg::REG_LONG_PRESS) begin
                    long_ms = i_pwdata[15:0];
                end else begin
                    deb_cnt = i_pwdata[7:0];
                end
            end
        end
        pending_n <= expected_reports.size();
    end

endmodule

@@ verif/tb.sv @@
`timescale 1ns / 1ps

module tb;

    localparam int CYCLE_LIMIT = 200000;
    localparam int LONG_HOLD   = 300;

    logic                        clk = 1'b0;
    logic                        i_rst_n;
    logic                        i_valid;
    logic                        o_stall;
    logic                        i_level;
    logic                        i_edge_seen;
    logic [31:0]                 i_now_ms;
    logic                        o_valid;
    logic                        i_stall;
    logic [1:0]                  o_event_res;
    logic [1:0]                  o_fsm_state;
    logic [31:0]                 o_press_duration;
    logic                        psel;
    logic                        penable;
    logic                        pwrite;
    logic [bdlp_pkg::ADDR_W-1:0] paddr;
    logic [31:0]                 pwdata;
    logic [31:0]                 prdata;
    logic                        pready;

    int chk_fails;
    int chk_pending;

    int cycles      = 0;
    int polls_sent  = 0;
    int burst_left  = 0;
    int gap_max     = 0;
    int step_max    = 1;
    int hold_req    = 0;
    int hold_ack    = 0;
    int hold_left   = 0;
    int stall_pct   = 0;
    int stall_phase = 0;

    logic [31:0] tnow;
    logic [15:0] cur_long;
    logic [7:0]  cur_deb;

    always #5 clk = ~clk;

    button_debounce_long_press_fsm uut (
        .i_clk            (clk),
        .i_rst_n          (i_rst_n),
        .i_valid          (i_valid),
        .o_stall          (o_stall),
        .i_level          (i_level),
        .i_edge_seen      (i_edge_seen),
        .i_now_ms         (i_now_ms),
        .o_valid          (o_valid),
        .i_stall          (i_stall),
        .o_event_res      (o_event_res),
        .o_fsm_state      (o_fsm_state),
        .o_press_duration (o_press_duration),
        .psel             (psel),
        .penable          (penable),
        .pwrite           (pwrite),
        .paddr            (paddr),
        .pwdata           (pwdata),
        .prdata           (prdata),
        .pready           (pready)
    );

    bdlp_report_checker chk (
        .i_clk            (clk),
        .i_rst_n          (i_rst_n),
        .i_poll_valid     (i_valid),
        .i_poll_stall     (o_stall),
        .i_level          (i_level),
        .i_edge_seen      (i_edge_seen),
        .i_now_ms         (i_now_ms),
        .i_res_valid      (o_valid),
        .i_res_stall      (i_stall),
        .i_event_res      (o_event_res),
        .i_fsm_state      (o_fsm_state),
        .i_press_duration (o_press_duration),
        .i_psel           (psel),
        .i_penable        (penable),
        .i_pwrite         (pwrite),
        .i_pready         (pready),
        .i_paddr          (paddr),
        .i_pwdata         (pwdata),
        .o_fail_count     (chk_fails),
        .o_pending        (chk_pending)
    );

    always @(posedge clk) begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT) begin
            $display("tb: FAIL");
            $finish;
        end
    end

    // Result side: a long hold when asked, else stall in changing proportions.
    always @(posedge clk) begin
        if (hold_left > 0) begin
            hold_left <= hold_left - 1;
            i_stall   <= 1'b1;
        end else if (hold_req != hold_ack) begin
            hold_ack  <= hold_req;
            hold_left <= LONG_HOLD;
            i_stall   <= 1'b1;
        end else begin
            if (stall_phase == 0) begin
                stall_phase <= $urandom_range(16, 96);
                case ($urandom_range(0, 3))
                    0: stall_pct <= 0;
                    1: stall_pct <= 25;
                    2: stall_pct <= 50;
                    default: stall_pct <= 85;
                endcase
            end else begin
                stall_phase <= stall_phase - 1;
            end
            i_stall <= ($urandom_range(0, 99) < stall_pct);
        end
    end

    task automatic send_poll(input logic lvl, input logic edg, input logic [31:0] now);
        if (burst_left == 0) begin
            if (gap_max > 0) begin
                i_valid <= 1'b0;
                repeat ($urandom_range(1, gap_max)) @(posedge clk);
            end
            burst_left = $urandom_range(1, 24);
        end
        burst_left--;
        i_valid     <= 1'b1;
        i_level     <= lvl;
        i_edge_seen <= edg;
        i_now_ms    <= now;
        @(posedge clk);
        while (o_stall) @(posedge clk);
        polls_sent++;
    endtask

    // Hold the poll side until every result word is back, then let the pipe settle.
    task automatic drain_results();
        i_valid <= 1'b0;
        burst_left = 0;
        @(posedge clk);
        while (chk_pending != 0) @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    task automatic write_reg(input logic idx, input logic [31:0] val);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= val;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        while (!pready) @(posedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    task automatic configure(input logic [15:0] long_ms, input logic [7:0] deb);
        cur_long = long_ms;
        cur_deb  = deb;
        write_reg(bdlp_pkg::REG_LONG_PRESS, {16'($urandom_range(0, 65535)), long_ms});
        write_reg(bdlp_pkg::REG_DEBOUNCE, {24'($urandom_range(0, 32'h00FF_FFFF)), deb});
    endtask

    task automatic next_poll(input logic lvl, input logic edg);
        tnow = tnow + $urandom_range(0, step_max);
        send_poll(lvl, edg, tnow);
    endtask

    task automatic noise_poll();
        send_poll(1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)), $urandom());
    endtask

    // Idle, edge, debounce (with the odd bounce), hold, release.
    task automatic press_sequence();
        int lows;
        int holds;
        repeat ($urandom_range(0, 3)) next_poll(1'b1, $urandom_range(0, 7) == 0);
        next_poll(1'b0, 1'b1);
        lows = int'(cur_deb) + $urandom_range(0, 3) - 2;
        for (int k = 0; k < lows; k++) begin
            next_poll($urandom_range(0, 39) == 0, 1'b0);
        end
        holds = $urandom_range(1, 30);
        repeat (holds) next_poll(1'b0, $urandom_range(0, 9) == 0);
        next_poll(1'b1, $urandom_range(0, 7) == 0);
    endtask

    initial begin
        int phase_end;
        i_rst_n     = 1'b0;
        i_valid     = 1'b0;
        i_level     = 1'b1;
        i_edge_seen = 1'b0;
        i_now_ms    = '0;
        i_stall     = 1'b0;
        psel        = 1'b0;
        penable     = 1'b0;
        pwrite      = 1'b0;
        paddr       = '0;
        pwdata      = '0;
        tnow        = '0;
        repeat (6) @(posedge clk);
        i_rst_n <= 1'b1;
        @(posedge clk);

        // Zero debounce and zero hold time: accept and fire long on the edge poll.
        configure(16'd0, 8'd0);
        send_poll(1'b1, 1'b0, 32'd0);
        send_poll(1'b0, 1'b1, 32'hFFFF_FFF0);
        send_poll(1'b0, 1'b1, 32'hFFFF_FFFF);
        send_poll(1'b0, 1'b0, 32'd5);
        send_poll(1'b1, 1'b0, 32'd6);
        drain_results();

        // Longest hold time: bounce back to idle, then a short press.
        configure(16'hFFFF, 8'd3);
        send_poll(1'b0, 1'b1, 32'd100);
        send_poll(1'b1, 1'b0, 32'd101);
        send_poll(1'b0, 1'b1, 32'd102);
        send_poll(1'b0, 1'b0, 32'd103);
        send_poll(1'b0, 1'b0, 32'd104);
        send_poll(1'b0, 1'b0, 32'd200);
        send_poll(1'b1, 1'b0, 32'd300);
        send_poll(1'b0, 1'b0, 32'd400);
        send_poll(1'b1, 1'b1, 32'd500);
        drain_results();

        // Long press reached exactly at the hold time, then a silent release.
        configure(16'd10, 8'd1);
        send_poll(1'b0, 1'b1, 32'd0);
        send_poll(1'b0, 1'b0, 32'd9);
        send_poll(1'b0, 1'b0, 32'd10);
        send_poll(1'b0, 1'b0, 32'd20);
        send_poll(1'b1, 1'b0, 32'd21);

        for (int ph = 0; ph < 7; ph++) begin
            drain_results();
            case (ph)
                3: configure(16'hFFFF, 8'hFF);
                5: configure(16'd1, 8'd1);
                default: configure(16'($urandom_range(1, 80)), 8'($urandom_range(1, 6)));
            endcase
            step_max = int'(cur_long) / 8 + 1;
            tnow     = $urandom();
            gap_max  = (ph % 3 == 1) ? 0 : $urandom_range(1, 6);
            if (ph == 2) begin
                // Stall results for a long stretch while polls keep coming.
                hold_req   = hold_req + 1;
                burst_left = 200;
            end
            phase_end = polls_sent + 120;
            while (polls_sent < phase_end) begin
                if ($urandom_range(0, 9) == 0) begin
                    repeat ($urandom_range(1, 5)) noise_poll();
                end else begin
                    press_sequence();
                end
            end
        end

        drain_results();
        repeat (8) @(posedge clk);
        if (chk_fails == 0) begin
            $display("tb: PASS");
        end else begin
            $display("tb: FAIL");
        end
        $finish;
    end

endmodule
